@@ hw/rtl/ethl4_pkg.sv @@
// Shared types, constants and helpers for the Ethernet/IP/L4 header parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package ethl4_pkg;

  localparam int MAX_FRAME_DEF = 4096;

  localparam int ETH_HDR_BYTES   = 14;
  localparam int MIN_FRAME_BYTES = 34;
  localparam int IPV6_MIN_FRAME  = 54;
  localparam int TCP_MIN_BYTES   = 20;
  localparam int UDP_HDR_BYTES   = 8;
  localparam int IHL_MIN         = 5;
  localparam int DOFF_MIN        = 5;
  localparam int IP_VERSION_4    = 4;

  localparam int L4S_W = 7;   // L4 start is at most 14 + 15*4
  localparam int OFF_W = 13;  // payload offset / length width

  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] KIND_IPV4 = 16'h0800;
  localparam logic [15:0] KIND_IPV6 = 16'h86DD;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_BAD_KIND  = 3'd2,
    ST_BAD_IP    = 3'd3,
    ST_BAD_TCP   = 3'd4,
    ST_TOO_LONG  = 3'd5
  } status_t;

  // Header fields captured across one frame
  typedef struct packed {
    logic [15:0] kind;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [3:0]  doff;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
  } hdr_t;

  // Frame offset of the L4 header
  function automatic logic [L4S_W-1:0] l4_start(input logic [15:0] kind,
                                                input logic [3:0] ihl);
    logic [L4S_W-1:0] res;
    if (kind == KIND_IPV6) begin
      res = L4S_W'(ETH_HDR_BYTES + 40);
    end else begin
      res = L4S_W'(ETH_HDR_BYTES) + L4S_W'({ihl, 2'b00});
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ethl4_capture.sv @@
// Input beat register and per-frame header capture; hands a frame summary on.
// Depends on ethl4_pkg.
`default_nettype none

module ethl4_capture import ethl4_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_DEF,
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       frame_byte,
  input  wire logic             last_byte,
  output logic                  sum_valid,
  input  wire logic             sum_ready,
  output hdr_t                  sum_hdr,
  output logic [POS_W-1:0]      sum_len
);

  logic             buf_valid;
  logic [7:0]       buf_byte;
  logic             buf_last;
  logic             buf_go;
  logic             slot_free;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  hdr_t             hdr;
  hdr_t             hdr_next;

  logic             cap_en;
  logic             is4;
  logic             is6;
  logic [L4S_W-1:0] l4s;
  logic [POS_W-1:0] rel;

  assign slot_free = !sum_valid || sum_ready;
  // Only the closing beat needs room in the summary register
  assign buf_go    = buf_valid && (!buf_last || slot_free);
  assign in_ready  = !buf_valid || buf_go;

  assign cap_en   = pos <= POS_W'(MAX_FRAME_BYTES);
  assign pos_next = cap_en ? pos + POS_W'(1) : pos;
  assign is4      = hdr.kind == KIND_IPV4;
  assign is6      = hdr.kind == KIND_IPV6;
  assign l4s      = l4_start(hdr.kind, hdr.ihl);
  assign rel      = pos - POS_W'(l4s);

  always_comb begin
    hdr_next = hdr;
    if (cap_en) begin
      if (pos == POS_W'(12)) hdr_next.kind[15:8] = buf_byte;
      if (pos == POS_W'(13)) hdr_next.kind[7:0]  = buf_byte;
      if (pos == POS_W'(14)) begin
        hdr_next.ver = buf_byte[7:4];
        hdr_next.ihl = buf_byte[3:0];
      end
      if (is4) begin
        if (pos == POS_W'(23)) hdr_next.proto = buf_byte;
        if (pos >= POS_W'(26) && pos <= POS_W'(29)) begin
          hdr_next.src_addr = {hdr.src_addr[23:0], buf_byte};
        end
        if (pos >= POS_W'(30) && pos <= POS_W'(33)) begin
          hdr_next.dst_addr = {hdr.dst_addr[23:0], buf_byte};
        end
      end else if (is6) begin
        if (pos == POS_W'(20)) hdr_next.proto = buf_byte;
        if (pos >= POS_W'(22) && pos <= POS_W'(25)) begin
          hdr_next.src_addr = {hdr.src_addr[23:0], buf_byte};
        end
        if (pos >= POS_W'(38) && pos <= POS_W'(41)) begin
          hdr_next.dst_addr = {hdr.dst_addr[23:0], buf_byte};
        end
      end
      if (pos > POS_W'(ETH_HDR_BYTES) && pos >= POS_W'(l4s)) begin
        if (rel <= POS_W'(1)) begin
          hdr_next.l4_sport = {hdr.l4_sport[7:0], buf_byte};
        end else if (rel <= POS_W'(3)) begin
          hdr_next.l4_dport = {hdr.l4_dport[7:0], buf_byte};
        end else if (rel == POS_W'(12)) begin
          hdr_next.doff = buf_byte[7:4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      pos       <= '0;
      hdr       <= '0;
      sum_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        buf_valid <= in_valid;
      end
      if (buf_go) begin
        if (buf_last) begin
          pos <= '0;
          hdr <= '0;
        end else begin
          pos <= pos_next;
          hdr <= hdr_next;
        end
      end
      if (buf_go && buf_last) begin
        sum_valid <= 1'b1;
      end else if (sum_ready) begin
        sum_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      buf_byte <= frame_byte;
      buf_last <= last_byte;
    end
    if (buf_go && buf_last) begin
      sum_hdr <= hdr_next;
      sum_len <= pos_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ethl4_check.sv @@
// Frame checks on the captured summary and the result register.
// Depends on ethl4_pkg.
`default_nettype none

module ethl4_check import ethl4_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_DEF,
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             sum_valid,
  output logic                  sum_ready,
  input  wire hdr_t             sum_hdr,
  input  wire logic [POS_W-1:0] sum_len,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [2:0]            status,
  output logic                  is_ipv6,
  output logic [31:0]           source_address,
  output logic [31:0]           dest_address,
  output logic [7:0]            l4_protocol,
  output logic [15:0]           source_port,
  output logic [15:0]           dest_port,
  output logic [OFF_W-1:0]      payload_offset,
  output logic [OFF_W-1:0]      payload_length
);

  logic             is4;
  logic             is6;
  logic [L4S_W-1:0] l4s;
  logic [POS_W-1:0] l4len;
  logic [POS_W-1:0] doff_bytes;
  status_t          st;
  logic [15:0]      sp;
  logic [15:0]      dp;
  logic [OFF_W-1:0] off;
  logic [POS_W-1:0] plen;

  assign sum_ready  = !out_valid || out_ready;
  assign is4        = sum_hdr.kind == KIND_IPV4;
  assign is6        = sum_hdr.kind == KIND_IPV6;
  assign l4s        = l4_start(sum_hdr.kind, sum_hdr.ihl);
  assign l4len      = sum_len - POS_W'(l4s);
  assign doff_bytes = POS_W'({sum_hdr.doff, 2'b00});

  always_comb begin
    st   = ST_OK;
    sp   = '0;
    dp   = '0;
    off  = OFF_W'(l4s);
    plen = l4len;
    if (sum_len > POS_W'(MAX_FRAME_BYTES)) begin
      st = ST_TOO_LONG;
    end else if (sum_len < POS_W'(MIN_FRAME_BYTES)) begin
      st = ST_TOO_SHORT;
    end else if (is4 && (sum_hdr.ver != 4'(IP_VERSION_4) || sum_hdr.ihl < 4'(IHL_MIN) ||
                         POS_W'({sum_hdr.ihl, 2'b00}) >
                         sum_len - POS_W'(ETH_HDR_BYTES))) begin
      st = ST_BAD_IP;
    end else if (is6 && sum_len < POS_W'(IPV6_MIN_FRAME)) begin
      st = ST_TOO_SHORT;
    end else if (!is4 && !is6) begin
      st = ST_BAD_KIND;
    end else if (sum_hdr.proto == PROTO_TCP && l4len >= POS_W'(TCP_MIN_BYTES)) begin
      if (sum_hdr.doff < 4'(DOFF_MIN) || doff_bytes > l4len) begin
        st = ST_BAD_TCP;
      end else begin
        sp   = sum_hdr.l4_sport;
        dp   = sum_hdr.l4_dport;
        off  = OFF_W'(l4s) + OFF_W'({sum_hdr.doff, 2'b00});
        plen = l4len - doff_bytes;
      end
    end else if (sum_hdr.proto == PROTO_UDP && l4len >= POS_W'(UDP_HDR_BYTES)) begin
      sp   = sum_hdr.l4_sport;
      dp   = sum_hdr.l4_dport;
      off  = OFF_W'(l4s) + OFF_W'(UDP_HDR_BYTES);
      plen = l4len - POS_W'(UDP_HDR_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_ready) begin
      out_valid <= sum_valid;
    end
  end

  // Error results carry only the status
  always_ff @(posedge clk) begin
    if (sum_ready && sum_valid) begin
      status <= st;
      if (st == ST_OK) begin
        is_ipv6        <= is6;
        source_address <= sum_hdr.src_addr;
        dest_address   <= sum_hdr.dst_addr;
        l4_protocol    <= sum_hdr.proto;
        source_port    <= sp;
        dest_port      <= dp;
        payload_offset <= off;
        payload_length <= OFF_W'(plen);
      end else begin
        is_ipv6        <= 1'b0;
        source_address <= '0;
        dest_address   <= '0;
        l4_protocol    <= '0;
        source_port    <= '0;
        dest_port      <= '0;
        payload_offset <= '0;
        payload_length <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ethernet_ip_l4_header_parser.sv @@
// Top level of the Ethernet/IPv4/IPv6/TCP/UDP header parser.
// Depends on ethl4_pkg, ethl4_capture, ethl4_check.
//
//   channel | signals                            | beat
//   --------+------------------------------------+---------------------------------
//   in      | in_valid / in_ready                | one frame byte, last_byte marks end
//   out     | out_valid / out_ready              | one result per frame
//
// One byte per cycle unless a closing byte finds the summary register full; each
// byte passes the input register and one capture step. The last byte loads the
// input register when it is taken; the frame's summary then moves on through the
// summary register to the result register, which presents the result.
// Reset clears the byte count, captured header and all valid flags.
// A stalled result holds the summary register; bytes keep flowing until the
// next closing byte finds that register still full.
`default_nettype none

module ethernet_ip_l4_header_parser import ethl4_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        frame_byte,
  input  wire logic              last_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             status,
  output logic                   is_ipv6,
  output logic [31:0]            source_address,
  output logic [31:0]            dest_address,
  output logic [7:0]             l4_protocol,
  output logic [15:0]            source_port,
  output logic [15:0]            dest_port,
  output logic [OFF_W-1:0]       payload_offset,
  output logic [OFF_W-1:0]       payload_length
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 2);

  logic             sum_valid;
  logic             sum_ready;
  hdr_t             sum_hdr;
  logic [POS_W-1:0] sum_len;

  ethl4_capture #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_capture (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .sum_valid  (sum_valid),
    .sum_ready  (sum_ready),
    .sum_hdr    (sum_hdr),
    .sum_len    (sum_len)
  );

  ethl4_check #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_check (
    .clk            (clk),
    .rst            (rst),
    .sum_valid      (sum_valid),
    .sum_ready      (sum_ready),
    .sum_hdr        (sum_hdr),
    .sum_len        (sum_len),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .is_ipv6        (is_ipv6),
    .source_address (source_address),
    .dest_address   (dest_address),
    .l4_protocol    (l4_protocol),
    .source_port    (source_port),
    .dest_port      (dest_port),
    .payload_offset (payload_offset),
    .payload_length (payload_length)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ethl4_checker.sv @@
// Port-level assertions for the header parser, bound to the top level.
// Depends on ethl4_pkg and ethernet_ip_l4_header_parser.
`default_nettype none

module ethl4_checker import ethl4_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [2:0]           status,
  input wire logic                 is_ipv6,
  input wire logic [31:0]          source_address,
  input wire logic [31:0]          dest_address,
  input wire logic [7:0]           l4_protocol,
  input wire logic [15:0]          source_port,
  input wire logic [15:0]          dest_port,
  input wire logic [OFF_W-1:0]     payload_offset,
  input wire logic [OFF_W-1:0]     payload_length
);

  logic err_fields_zero;

  assign err_fields_zero = !is_ipv6 && source_address == '0 && dest_address == '0 &&
                           l4_protocol == '0 && source_port == '0 && dest_port == '0 &&
                           payload_offset == '0 && payload_length == '0;

  // A held result keeps its status and payload length
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_length))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> err_fields_zero)
    else $error("error result carries nonzero fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_TOO_LONG)
    else $error("status code out of range");

  a_ok_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |->
      payload_offset >= OFF_W'(MIN_FRAME_BYTES) &&
      (!is_ipv6 || payload_offset >= OFF_W'(IPV6_MIN_FRAME)))
    else $error("good result with payload inside the IP header");

  // Input only stalls behind a result that is waiting on the receiver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no held result");

endmodule

bind ethernet_ip_l4_header_parser ethl4_checker u_ethl4_checker (.*);

`default_nettype wire

@@ dv/ethernet_ip_l4_header_parser_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ethernet_ip_l4_header_parser: directed and random frames
// streamed byte by byte, results checked against an in-bench header parse.
// Depends on ethl4_pkg and the parser RTL only.

module ethernet_ip_l4_header_parser_tb;
  import ethl4_pkg::*;

  localparam int FRAME_LIMIT      = MAX_FRAME_DEF;
  localparam int RESET_CYCLES     = 6;
  localparam int CYCLE_LIMIT      = 400_000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int RANDOM_BYTES     = 500;
  localparam int RANDOM_FRAMES    = 4;
  localparam int LONG_HOLD_AFTER  = 10;
  localparam int LONG_HOLD_CYCLES = 2000;

  localparam logic [15:0] KIND_ARP     = 16'h0806;
  localparam logic [15:0] KIND_ALL_ONE = 16'hFFFF;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_ICMP6  = 8'd58;
  localparam logic [3:0]  IP_VERSION_6 = 4'd6;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;  // hold this beat until every result is back
  } frame_beat_t;

  typedef struct {
    status_t          status;
    logic             is_v6;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [7:0]       proto;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] plen;
  } summary_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] frame_byte = '0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] status;
  logic is_ipv6;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0] l4_protocol;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [OFF_W-1:0] payload_offset;
  logic [OFF_W-1:0] payload_length;

  ethernet_ip_l4_header_parser #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_byte(frame_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .is_ipv6(is_ipv6),
    .source_address(source_address),
    .dest_address(dest_address),
    .l4_protocol(l4_protocol),
    .source_port(source_port),
    .dest_port(dest_port),
    .payload_offset(payload_offset),
    .payload_length(payload_length)
  );

  frame_beat_t pending[$];
  summary_t    results_due[$];
  logic [7:0]  frame_buf[];
  int mismatches = 0;
  int queued_bytes = 0;
  int cycles = 0;

  // parse state for the frame in flight
  logic [12:0] hdr_pos = '0;
  logic [15:0] kind_q = '0;
  logic [3:0]  ver_q = '0;
  logic [3:0]  ihl_q = '0;
  logic [7:0]  proto_q = '0;
  logic [31:0] src_q = '0;
  logic [31:0] dst_q = '0;
  logic [3:0]  doff_q = '0;
  logic [15:0] sport_q = '0;
  logic [15:0] dport_q = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int l4_offset();
    if (kind_q == KIND_IPV6) begin
      return IPV6_MIN_FRAME;
    end
    return ETH_HDR_BYTES + int'(ihl_q) * 4;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    int pos, len, l4s, l4len, rel;
    summary_t r;
    pos = int'(hdr_pos);
    if (pos <= FRAME_LIMIT) begin
      if (pos == 12) kind_q[15:8] = b;
      if (pos == 13) kind_q[7:0] = b;
      if (pos == 14) {ver_q, ihl_q} = b;
      if (kind_q == KIND_IPV4) begin
        if (pos == 23) proto_q = b;
        if (pos >= 26 && pos <= 29) src_q = {src_q[23:0], b};
        if (pos >= 30 && pos <= 33) dst_q = {dst_q[23:0], b};
      end else if (kind_q == KIND_IPV6) begin
        if (pos == 20) proto_q = b;
        if (pos >= 22 && pos <= 25) src_q = {src_q[23:0], b};
        if (pos >= 38 && pos <= 41) dst_q = {dst_q[23:0], b};
      end
      l4s = l4_offset();
      if (pos > ETH_HDR_BYTES && pos >= l4s) begin
        rel = pos - l4s;
        if (rel <= 1) sport_q = {sport_q[7:0], b};
        else if (rel <= 3) dport_q = {dport_q[7:0], b};
        else if (rel == 12) doff_q = b[7:4];
      end
      hdr_pos = hdr_pos + 13'd1;
    end
    if (last) begin
      len = int'(hdr_pos);
      r = '{status: ST_OK, default: '0};
      if (len > FRAME_LIMIT) begin
        r.status = ST_TOO_LONG;
      end else if (len < MIN_FRAME_BYTES) begin
        r.status = ST_TOO_SHORT;
      end else if (kind_q == KIND_IPV4 && (ver_q != IP_VERSION_4 || ihl_q < IHL_MIN ||
                   int'(ihl_q) * 4 > len - ETH_HDR_BYTES)) begin
        r.status = ST_BAD_IP;
      end else if (kind_q == KIND_IPV6 && len < IPV6_MIN_FRAME) begin
        r.status = ST_TOO_SHORT;
      end else if (kind_q != KIND_IPV4 && kind_q != KIND_IPV6) begin
        r.status = ST_BAD_KIND;
      end else begin
        l4s = l4_offset();
        l4len = len - l4s;
        r.off = OFF_W'(l4s);
        r.plen = OFF_W'(l4len);
        if (proto_q == PROTO_TCP && l4len >= TCP_MIN_BYTES) begin
          if (doff_q < DOFF_MIN || int'(doff_q) * 4 > l4len) begin
            r.status = ST_BAD_TCP;
          end else begin
            r.sport = sport_q;
            r.dport = dport_q;
            r.off = OFF_W'(l4s + int'(doff_q) * 4);
            r.plen = OFF_W'(l4len - int'(doff_q) * 4);
          end
        end else if (proto_q == PROTO_UDP && l4len >= UDP_HDR_BYTES) begin
          r.sport = sport_q;
          r.dport = dport_q;
          r.off = OFF_W'(l4s + UDP_HDR_BYTES);
          r.plen = OFF_W'(l4len - UDP_HDR_BYTES);
        end
        if (r.status == ST_OK) begin
          r.is_v6 = (kind_q == KIND_IPV6);
          r.src = src_q;
          r.dst = dst_q;
          r.proto = proto_q;
        end else begin
          r = '{status: ST_BAD_TCP, default: '0};
        end
      end
      results_due.push_back(r);
      hdr_pos = '0;
      kind_q = '0;
      ver_q = '0;
      ihl_q = '0;
      proto_q = '0;
      src_q = '0;
      dst_q = '0;
      doff_q = '0;
      sport_q = '0;
      dport_q = '0;
    end
  endtask

  function automatic void put(int pos, logic [7:0] v);
    if (pos < frame_buf.size()) frame_buf[pos] = v;
  endfunction

  // Random fill, then header fields laid over it wherever the frame is long enough; L4 fields only if L4 start >= 34
  task automatic queue_frame(input logic [15:0] kind, input logic [3:0] ver,
                             input logic [3:0] ihl, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] sport, input logic [15:0] dport,
                             input logic [3:0] doff, input int len, input bit drain);
    int l4s;
    frame_buf = new[len];
    foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
    put(12, kind[15:8]);
    put(13, kind[7:0]);
    if (kind == KIND_IPV6) begin
      put(14, {ver, 4'($urandom)});
      put(20, proto);
      for (int k = 0; k < 4; k++) begin
        put(22 + k, src[31 - 8 * k -: 8]);
        put(38 + k, dst[31 - 8 * k -: 8]);
      end
      l4s = IPV6_MIN_FRAME;
    end else begin
      put(14, {ver, ihl});
      put(23, proto);
      for (int k = 0; k < 4; k++) begin
        put(26 + k, src[31 - 8 * k -: 8]);
        put(30 + k, dst[31 - 8 * k -: 8]);
      end
      l4s = ETH_HDR_BYTES + int'(ihl) * 4;
    end
    if (l4s >= MIN_FRAME_BYTES) begin
      put(l4s, sport[15:8]);
      put(l4s + 1, sport[7:0]);
      put(l4s + 2, dport[15:8]);
      put(l4s + 3, dport[7:0]);
      put(l4s + 12, {doff, 4'($urandom)});
    end
    foreach (frame_buf[i]) pending.push_back('{frame_buf[i], i == len - 1, drain && i == 0});
    queued_bytes += len;
  endtask

  task automatic queue_random_frame(input bit drain);
    int pick, l4s, hdr, len;
    logic [15:0] kind;
    logic [3:0] ver, ihl, doff;
    logic [7:0] proto;
    pick = $urandom_range(0, 99);
    kind = ($urandom_range(0, 9) < 6) ? KIND_IPV4 : KIND_IPV6;
    ver = (kind == KIND_IPV4) ? 4'(IP_VERSION_4) : IP_VERSION_6;
    ihl = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(IHL_MIN, 15)) : 4'(IHL_MIN);
    doff = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(DOFF_MIN, 15))
                                       : 4'($urandom_range(DOFF_MIN, 8));
    case ($urandom_range(0, 4))
      0, 1: proto = PROTO_TCP;
      2, 3: proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    l4s = (kind == KIND_IPV6) ? IPV6_MIN_FRAME : ETH_HDR_BYTES + int'(ihl) * 4;
    hdr = (proto == PROTO_TCP) ? int'(doff) * 4 : (proto == PROTO_UDP) ? UDP_HDR_BYTES : 0;
    len = l4s + hdr + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                    : $urandom_range(0, 40));
    if (pick >= 70 && pick < 85) begin
      // one corruption on an otherwise sane frame
      case ($urandom_range(0, 3))
        0: ver = 4'($urandom);
        1: ihl = 4'($urandom);
        2: doff = 4'($urandom);
        default: len = $urandom_range(1, len);
      endcase
    end else if (pick >= 85) begin
      if ($urandom_range(0, 1) == 1) kind = 16'($urandom);
      ver = 4'($urandom);
      ihl = 4'($urandom);
      doff = 4'($urandom);
      proto = 8'($urandom);
      len = $urandom_range(1, 120);
    end
    queue_frame(kind, ver, ihl, proto, $urandom, $urandom, 16'($urandom), 16'($urandom),
                doff, len, drain);
  endtask

  // Sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    logic launch;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) parse_byte(frame_byte, last_byte);
      if (!in_valid || in_ready) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() != 0) begin
          launch = !(pending[0].drain && results_due.size() != 0);
        end
        if (launch) begin
          frame_byte <= pending[0].data;
          last_byte <= pending[0].last;
          pending.pop_front();
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        in_valid <= launch;
      end
    end
  end

  // Receiver: alternates steady and stalling stretches, plus one long hold-off
  int results_taken = 0;
  int hold_left = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit steady = 1'b0;
  bit long_hold_done = 1'b0;

  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) results_taken++;
      if (!long_hold_done && results_taken >= LONG_HOLD_AFTER) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        steady = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(100, 600);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (steady) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
      end
      out_ready <= rdy;
    end
  end

  function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    summary_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d", $time, status);
      end else begin
        exp_r = results_due.pop_front();
        match_field("status", 32'(exp_r.status), 32'(status));
        match_field("is_ipv6", 32'(exp_r.is_v6), 32'(is_ipv6));
        match_field("source_address", exp_r.src, source_address);
        match_field("dest_address", exp_r.dst, dest_address);
        match_field("l4_protocol", 32'(exp_r.proto), 32'(l4_protocol));
        match_field("source_port", 32'(exp_r.sport), 32'(source_port));
        match_field("dest_port", 32'(exp_r.dport), 32'(dest_port));
        match_field("payload_offset", 32'(exp_r.off), 32'(payload_offset));
        match_field("payload_length", 32'(exp_r.plen), 32'(payload_length));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int start_bytes, random_frames;
    // well-formed IPv4, extreme field values
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, '1, '1, '1, '1, 5, 60, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_UDP, '0, '0, '0, '0, 0, 42, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_ICMP, $urandom, $urandom, 0, 0, 0,
                MIN_FRAME_BYTES, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 15, PROTO_TCP, $urandom, $urandom, 16'h8000,
                16'h0001, 15, 134, 0);
    // data offset exactly fills the L4 bytes
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, $urandom, $urandom, 80, 443, 8, 66, 0);
    // L4 too short for a TCP or UDP header: ports stay zero
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, $urandom, $urandom, 1, 2, 5, 53, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_UDP, $urandom, $urandom, 1, 2, 0, 41, 0);
    // IP header errors
    queue_frame(KIND_IPV4, IP_VERSION_6, 5, PROTO_TCP, $urandom, $urandom, 1, 2, 5, 60, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 4, PROTO_TCP, $urandom, $urandom, 1, 2, 5, 60, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 0, PROTO_UDP, $urandom, $urandom, 1, 2, 5, 60, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 15, PROTO_UDP, $urandom, $urandom, 1, 2, 5, 60, 0);
    // TCP data offset errors
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, $urandom, $urandom, 1, 2, 4, 60, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, $urandom, $urandom, 1, 2, 15, 74, 0);
    // IPv6
    queue_frame(KIND_IPV6, IP_VERSION_6, 0, PROTO_TCP, $urandom, $urandom, 1234, 22, 5, 74, 0);
    queue_frame(KIND_IPV6, IP_VERSION_6, 0, PROTO_UDP, '1, '1, '1, '1, 0, 62, 0);
    queue_frame(KIND_IPV6, IP_VERSION_6, 0, PROTO_UDP, $urandom, $urandom, 1, 2, 0, 53, 0);
    queue_frame(KIND_IPV6, IP_VERSION_6, 0, PROTO_UDP, $urandom, $urandom, 1, 2, 0,
                IPV6_MIN_FRAME, 0);
    queue_frame(KIND_IPV6, IP_VERSION_6, 0, PROTO_TCP, $urandom, $urandom, 1, 2, 3, 80, 0);
    // IPv6 version nibble is not checked
    queue_frame(KIND_IPV6, 4'd0, 0, PROTO_ICMP6, $urandom, $urandom, 1, 2, 0, 70, 0);
    // unknown ethertypes and short frames
    queue_frame(KIND_ARP, IP_VERSION_4, 5, PROTO_TCP, $urandom, $urandom, 1, 2, 5, 60, 0);
    queue_frame(KIND_ALL_ONE, IP_VERSION_4, 5, PROTO_UDP, $urandom, $urandom, 1, 2, 5, 40, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, '1, '1, '1, '1, 5, 1, 0);
    queue_frame(KIND_IPV4, IP_VERSION_4, 5, PROTO_TCP, '1, '1, '1, '1, 5,
                MIN_FRAME_BYTES - 1, 0);

    // random part starts only after the directed results have drained
    start_bytes = queued_bytes;
    queue_random_frame(1'b1);
    random_frames = 1;
    while (queued_bytes - start_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES) begin
      queue_random_frame(1'b0);
      random_frames++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ethl4_pkg.sv
hw/rtl/ethl4_capture.sv
hw/rtl/ethl4_check.sv
hw/rtl/ethernet_ip_l4_header_parser.sv
hw/rtl/ethl4_checker.sv
dv/ethernet_ip_l4_header_parser_tb.sv
